// File: rtl/radial_axis_force_unit_defines.svh
// Assertion macros shared by the radial axis force RTL.
`ifndef RADIAL_AXIS_FORCE_UNIT_DEFINES_SVH
`define RADIAL_AXIS_FORCE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define RAF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/raf_pkg.sv
// Shared constants and register codes for the radial axis force unit.
package raf_pkg;

  // Default field widths
  localparam int COORD_W_DEF = 32;
  localparam int ID_W_DEF    = 16;

  // Fixed point formats
  localparam int DIR_W     = 16;
  localparam int DIR_FRAC  = 14;
  localparam int UNIT_FRAC = 30;

  // Normalized magnitude, square root and quotient widths
  localparam int NORM_W   = 30;
  localparam int SUMSQ_W  = 62;
  localparam int ROOT_W   = 31;
  localparam int QUOT_W   = 31;

  // Register map
  localparam int REG_IDX_W = 3;
  typedef enum logic [REG_IDX_W-1:0] {
    REG_PT_X  = 3'd0,
    REG_PT_Y  = 3'd1,
    REG_PT_Z  = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5,
    REG_FMAG  = 3'd6
  } reg_idx_t;

  localparam logic signed [DIR_W-1:0] DIR_Z_RESET = 16'sd16384;

endpackage

// File: rtl/raf_div_lane.sv
// Pipelined restoring divider lane: rounded unit component u * 2^30 / n.
module raf_div_lane
  import raf_pkg::*;
(
  input  logic              clk,
  input  logic [QUOT_W:0]   en,
  input  logic [NORM_W-1:0] u_i,
  input  logic [ROOT_W-1:0] n_i,
  output logic [QUOT_W-1:0] q_o
);

  localparam int DVW = NORM_W + UNIT_FRAC + 2;

  logic [DVW-1:0]    rem_r [QUOT_W+1];
  logic [ROOT_W-1:0] n_r   [QUOT_W+1];
  logic [QUOT_W-1:0] q_r   [QUOT_W+1];

  // First stage: dividend with half the divisor added for rounding
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0] <= (DVW'(u_i) << UNIT_FRAC) + DVW'(n_i >> 1);
      n_r[0]   <= n_i;
      q_r[0]   <= '0;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar j = 1; j <= QUOT_W; j++) begin : g_step
    logic [DVW-1:0] dvs_w;
    assign dvs_w = DVW'(n_r[j-1]) << (QUOT_W - j);

    always_ff @(posedge clk) begin
      if (en[j]) begin
        n_r[j] <= n_r[j-1];
        if (rem_r[j-1] >= dvs_w) begin
          rem_r[j] <= rem_r[j-1] - dvs_w;
          q_r[j]   <= q_r[j-1] | (QUOT_W'(1) << (QUOT_W - j));
        end else begin
          rem_r[j] <= rem_r[j-1];
          q_r[j]   <= q_r[j-1];
        end
      end
    end
  end

  assign q_o = q_r[QUOT_W];

endmodule

// File: rtl/radial_axis_force_unit.sv
// Top level of the radial axis force unit: config registers and force pipeline.
//
// Use: a body request (id and Q16.16 position) enters on the in_ channel; one
// result (id, saturated Q16.16 force, on_axis flag) leaves on the out_ channel
// for every request, in order. A request is taken when in_valid is high and
// in_stall is low; a result is taken when out_valid is high and out_stall low.
// Throughput is one request per cycle while out_stall is low. The square root
// produces one root bit per stage and the divider lanes one quotient bit per stage.
// Every stage has its own valid bit; a stage loads whenever some stage at or
// after it is empty, so bubbles are squeezed out while out_stall holds, and
// in_stall rises only when every stage holds a request.
// Config must be written over the APB-style port only while the pipeline is empty;
// the block itself does not enforce this. Reset clears all valid bits and loads
// the register defaults (axis along z, zero point, zero magnitude).
`include "radial_axis_force_unit_defines.svh"
module radial_axis_force_unit
  import raf_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_W_DEF,
  parameter int ID_WIDTH    = ID_W_DEF,
  localparam int DATA_W     = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int ADDR_LSB   = (COORD_WIDTH > 32) ? 3 : 2,
  localparam int PADDR_W    = REG_IDX_W + ADDR_LSB
)(
  input  logic                          clk,
  input  logic                          rst_n,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  // body requests
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ID_WIDTH-1:0]           in_body_id,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_z,
  // force results
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ID_WIDTH-1:0]           out_body_id,
  output logic signed [COORD_WIDTH-1:0] out_force_x,
  output logic signed [COORD_WIDTH-1:0] out_force_y,
  output logic signed [COORD_WIDTH-1:0] out_force_z,
  output logic                          out_on_axis
);

  localparam int CW    = COORD_WIDTH;
  localparam int DW    = CW + 1;
  localparam int PW    = DW + DIR_W;
  localparam int SW    = PW + 2;
  localparam int TW    = SW - DIR_FRAC;
  localparam int QW    = TW + DIR_W;
  localparam int AW    = QW - DIR_FRAC;
  localparam int RW    = AW + 1;
  localparam int UW    = (RW > NORM_W + 1) ? RW : NORM_W + 1;
  localparam int NSTEP = $clog2(UW);
  localparam int SQW   = 2 * NORM_W;
  localparam int RMW   = SUMSQ_W + 1;
  localparam int ESW   = QUOT_W + 1;
  localparam int PRW   = CW + ESW;
  localparam int VW    = PRW - UNIT_FRAC;

  // Stage numbering
  localparam int ST_D   = 0;
  localparam int ST_P   = 1;
  localparam int ST_T   = 2;
  localparam int ST_Q   = 3;
  localparam int ST_R   = 4;
  localparam int ST_U   = 5;
  localparam int ST_N0  = 6;
  localparam int ST_SQ  = ST_N0 + NSTEP;
  localparam int ST_SS  = ST_SQ + 1;
  localparam int ST_RT0 = ST_SS + 1;
  localparam int ST_DV0 = ST_RT0 + ROOT_W;
  localparam int ST_SG  = ST_DV0 + QUOT_W + 1;
  localparam int ST_ML  = ST_SG + 1;
  localparam int ST_OUT = ST_ML + 1;
  localparam int NS     = ST_OUT + 1;

  // ---------------------------------------------------------------- config
  logic signed [CW-1:0]    pt_r  [3];
  logic signed [DIR_W-1:0] dir_r [3];
  logic signed [CW-1:0]    fmag_r;
  logic                    wr_w;
  reg_idx_t                widx_w;
  reg_idx_t                ridx_w;

  assign pready = 1'b1;
  assign wr_w   = psel && penable && pwrite;
  assign widx_w = reg_idx_t'(paddr[ADDR_LSB +: REG_IDX_W]);
  assign ridx_w = widx_w;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r[0]  <= '0;
      pt_r[1]  <= '0;
      pt_r[2]  <= '0;
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= DIR_Z_RESET;
      fmag_r   <= '0;
    end else if (wr_w) begin
      case (widx_w)
        REG_PT_X:  pt_r[0]  <= pwdata[CW-1:0];
        REG_PT_Y:  pt_r[1]  <= pwdata[CW-1:0];
        REG_PT_Z:  pt_r[2]  <= pwdata[CW-1:0];
        REG_DIR_X: dir_r[0] <= pwdata[DIR_W-1:0];
        REG_DIR_Y: dir_r[1] <= pwdata[DIR_W-1:0];
        REG_DIR_Z: dir_r[2] <= pwdata[DIR_W-1:0];
        REG_FMAG:  fmag_r   <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (ridx_w)
      REG_PT_X:  prdata = DATA_W'($unsigned(pt_r[0]));
      REG_PT_Y:  prdata = DATA_W'($unsigned(pt_r[1]));
      REG_PT_Z:  prdata = DATA_W'($unsigned(pt_r[2]));
      REG_DIR_X: prdata = DATA_W'($unsigned(dir_r[0]));
      REG_DIR_Y: prdata = DATA_W'($unsigned(dir_r[1]));
      REG_DIR_Z: prdata = DATA_W'($unsigned(dir_r[2]));
      REG_FMAG:  prdata = DATA_W'($unsigned(fmag_r));
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- control
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  // A stage loads when the output moves or it or any later stage is empty
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !out_stall || !(&v_r[NS-1:k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= (v_r & ~en) | ({v_r[NS-2:0], in_valid} & en);
    end
  end

  assign in_stall = !en[0];

  // ---------------------------------------------------------------- sideband
  logic [ID_WIDTH-1:0] id_r [NS];
  logic                ax_r [NS];
  logic [2:0]          ng_r [NS];
  logic [UW-1:0]       un_r [NSTEP+1][3];

  for (genvar k = 0; k < NS; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[k]) begin
        if (k == 0) begin
          id_r[k] <= in_body_id;
        end else begin
          id_r[k] <= id_r[(k == 0) ? 0 : k-1];
        end
        if (k < ST_N0) begin
          ax_r[k] <= 1'b0;
        end else if (k == ST_N0) begin
          ax_r[k] <= ((un_r[0][0] | un_r[0][1] | un_r[0][2]) == '0);
        end else begin
          ax_r[k] <= ax_r[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- offset
  logic signed [CW-1:0] pos_w [3];
  logic signed [DW-1:0] d_r   [3];
  logic signed [DW-1:0] dp_r  [3];
  logic signed [DW-1:0] dt_r  [3];
  logic signed [DW-1:0] dq_r  [3];
  logic signed [PW-1:0] p_r   [3];
  logic signed [SW-1:0] s_w;
  logic signed [TW-1:0] t_r;
  logic signed [QW-1:0] q_r   [3];
  logic signed [QW-1:0] qs_w  [3];
  logic signed [AW-1:0] qa_w  [3];
  logic signed [RW-1:0] r_r   [3];
  logic [RW-1:0]        abs_w [3];

  assign pos_w[0] = in_pos_x;
  assign pos_w[1] = in_pos_y;
  assign pos_w[2] = in_pos_z;

  // Dot product sum with half an LSB of the result added
  assign s_w = SW'(p_r[0]) + SW'(p_r[1]) + SW'(p_r[2])
             + SW'(1 << (DIR_FRAC - 1));

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign qs_w[i]  = q_r[i] + QW'(1 << (DIR_FRAC - 1));
    assign qa_w[i]  = qs_w[i][QW-1:DIR_FRAC];
    assign abs_w[i] = r_r[i][RW-1] ? RW'(-r_r[i]) : RW'(r_r[i]);

    // offset from the axis point
    always_ff @(posedge clk) begin
      if (en[ST_D]) d_r[i] <= DW'(pos_w[i]) - DW'(pt_r[i]);
    end
    // d times direction
    always_ff @(posedge clk) begin
      if (en[ST_P]) begin
        p_r[i]  <= PW'(d_r[i]) * PW'(dir_r[i]);
        dp_r[i] <= d_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en[ST_T]) dt_r[i] <= dp_r[i];
    end
    // axial length times direction
    always_ff @(posedge clk) begin
      if (en[ST_Q]) begin
        q_r[i]  <= QW'(t_r) * QW'(dir_r[i]);
        dq_r[i] <= dt_r[i];
      end
    end
    // radial offset
    always_ff @(posedge clk) begin
      if (en[ST_R]) r_r[i] <= RW'(dq_r[i]) - RW'(qa_w[i]);
    end
    // magnitude and sign
    always_ff @(posedge clk) begin
      if (en[ST_U]) begin
        un_r[0][i] <= UW'(abs_w[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_T]) t_r <= s_w[SW-1:DIR_FRAC];
  end

  // Sign flags enter at the magnitude stage
  for (genvar k = 0; k < NS; k++) begin : g_sign
    always_ff @(posedge clk) begin
      if (en[k]) begin
        if (k < ST_U) begin
          ng_r[k] <= '0;
        end else if (k == ST_U) begin
          ng_r[k] <= {r_r[2][RW-1], r_r[1][RW-1], r_r[0][RW-1]};
        end else begin
          ng_r[k] <= ng_r[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- normalize
  // Binary search shift: move the common leading one to the top bit
  for (genvar j = 0; j < NSTEP; j++) begin : g_norm
    localparam int SH = 1 << (NSTEP - 1 - j);
    logic [UW-1:0] mo_w;
    logic          sh_w;
    assign mo_w = un_r[j][0] | un_r[j][1] | un_r[j][2];
    assign sh_w = (mo_w[UW-1 -: SH] == '0);

    always_ff @(posedge clk) begin
      if (en[ST_N0 + j]) begin
        for (int i = 0; i < 3; i++) begin
          un_r[j+1][i] <= sh_w ? (un_r[j][i] << SH) : un_r[j][i];
        end
      end
    end
  end

  // ---------------------------------------------------------------- length
  logic [NORM_W-1:0]  uf_r [ROOT_W+2][3];
  logic [SQW-1:0]     sq_r [3];
  logic [SUMSQ_W-1:0] ss_r;
  logic [SUMSQ_W-1:0] rr_r [ROOT_W];
  logic [ROOT_W-1:0]  rq_r [ROOT_W];

  // squares of the normalized magnitudes
  always_ff @(posedge clk) begin
    if (en[ST_SQ]) begin
      for (int i = 0; i < 3; i++) begin
        uf_r[0][i] <= un_r[NSTEP][i][UW-1 -: NORM_W];
        sq_r[i]    <= SQW'(un_r[NSTEP][i][UW-1 -: NORM_W])
                    * SQW'(un_r[NSTEP][i][UW-1 -: NORM_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_SS]) begin
      ss_r    <= SUMSQ_W'(sq_r[0]) + SUMSQ_W'(sq_r[1]) + SUMSQ_W'(sq_r[2]);
      uf_r[1] <= uf_r[0];
    end
  end

  // Integer square root, one root bit per stage
  for (genvar j = 0; j < ROOT_W; j++) begin : g_root
    localparam int B = ROOT_W - 1 - j;
    logic [SUMSQ_W-1:0] rin_w;
    logic [ROOT_W-1:0]  qin_w;
    logic [RMW-1:0]     cand_w;
    if (j == 0) begin : g_first
      assign rin_w = ss_r;
      assign qin_w = '0;
    end else begin : g_next
      assign rin_w = rr_r[j-1];
      assign qin_w = rq_r[j-1];
    end
    assign cand_w = (RMW'(qin_w) << (B + 1)) | (RMW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en[ST_RT0 + j]) begin
        uf_r[j+2] <= uf_r[j+1];
        if (RMW'(rin_w) >= cand_w) begin
          rr_r[j] <= rin_w - cand_w[SUMSQ_W-1:0];
          rq_r[j] <= qin_w | (ROOT_W'(1) << B);
        end else begin
          rr_r[j] <= rin_w;
          rq_r[j] <= qin_w;
        end
      end
    end
  end

  // ---------------------------------------------------------------- divide
  logic [QUOT_W-1:0] qd_w [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    raf_div_lane u_div (
      .clk (clk),
      .en  (en[ST_DV0 +: QUOT_W+1]),
      .u_i (uf_r[ROOT_W+1][i]),
      .n_i (rq_r[ROOT_W-1]),
      .q_o (qd_w[i])
    );
  end

  // ---------------------------------------------------------------- scale
  logic signed [ESW-1:0] es_r  [3];
  logic signed [PRW-1:0] pr_r  [3];
  logic signed [PRW-1:0] prs_w [3];
  logic signed [VW-1:0]  vw_w  [3];
  logic signed [CW-1:0]  sat_w [3];
  logic signed [CW-1:0]  force_r [3];

  for (genvar i = 0; i < 3; i++) begin : g_scale
    assign prs_w[i] = pr_r[i] + PRW'(1 << (UNIT_FRAC - 1));
    assign vw_w[i]  = prs_w[i][PRW-1:UNIT_FRAC];

    // saturate to the coordinate width
    always_comb begin
      if ((vw_w[i][VW-1:CW-1] == '0) || (vw_w[i][VW-1:CW-1] == '1)) begin
        sat_w[i] = vw_w[i][CW-1:0];
      end else if (vw_w[i][VW-1]) begin
        sat_w[i] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        sat_w[i] = {1'b0, {(CW-1){1'b1}}};
      end
    end

    // signed unit component
    always_ff @(posedge clk) begin
      if (en[ST_SG]) begin
        es_r[i] <= ng_r[ST_SG-1][i] ? -ESW'(qd_w[i]) : ESW'(qd_w[i]);
      end
    end
    always_ff @(posedge clk) begin
      if (en[ST_ML]) pr_r[i] <= PRW'(fmag_r) * PRW'(es_r[i]);
    end
    always_ff @(posedge clk) begin
      if (en[ST_OUT]) force_r[i] <= ax_r[ST_OUT-1] ? '0 : sat_w[i];
    end
  end

  // ---------------------------------------------------------------- outputs
  assign out_valid   = v_r[NS-1];
  assign out_body_id = id_r[NS-1];
  assign out_on_axis = ax_r[NS-1];
  assign out_force_x = force_r[0];
  assign out_force_y = force_r[1];
  assign out_force_z = force_r[2];

  // ---------------------------------------------------------------- checks
  `RAF_ASSERT_NOW(a_axis_zero, out_valid && out_on_axis,
    out_force_x == '0 && out_force_y == '0 && out_force_z == '0,
    "on-axis result carries a nonzero force")
  `RAF_ASSERT_NOW(a_stall_full, in_stall, &v_r,
    "input stalled while the pipeline has an empty stage")
  `RAF_ASSERT_NEXT(a_take, in_valid && !in_stall,
    v_r[0] && id_r[0] == $past(in_body_id),
    "accepted request did not enter the first stage")
  `RAF_ASSERT_NOW(a_norm_top, v_r[ST_SQ] && !ax_r[ST_SQ],
    uf_r[0][0][NORM_W-1] || uf_r[0][1][NORM_W-1] || uf_r[0][2][NORM_W-1],
    "normalized magnitude lost its leading one")
  `RAF_ASSERT_NOW(a_root_low, v_r[ST_DV0-1] && !ax_r[ST_DV0-1],
    rq_r[ROOT_W-1][ROOT_W-1 -: 2] != '0,
    "vector length below the normalized bound")

endmodule

// File: tb/radial_axis_force_checker.sv
// Checker for the radial axis force unit: mirrors config, predicts forces, compares results.
module radial_axis_force_checker
  import raf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [15:0]        in_body_id,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [15:0]        out_body_id,
  input  logic signed [31:0] out_force_x,
  input  logic signed [31:0] out_force_y,
  input  logic signed [31:0] out_force_z,
  input  logic               out_on_axis,
  output int                 fail_count,
  output int                 pending_forces,
  output int                 forces_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0]        body_id;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic               on_axis;
  } force_result_t;

  // Mirror of the register file
  logic signed [31:0] axis_pt [3];
  logic signed [15:0] axis_dir [3];
  logic signed [31:0] force_mag;

  force_result_t expected_forces [$];

  // floor(sqrt(x)), bit by bit
  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] bit_w;
    root  = '0;
    bit_w = 64'd1 << 62;
    while (bit_w > x) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (x >= root + bit_w) begin
        x    = x - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  function automatic force_result_t radial_force(logic [15:0] id, logic signed [31:0] px,
                                                 logic signed [31:0] py, logic signed [31:0] pz);
    logic signed [127:0] ofs [3];
    logic signed [127:0] dir [3];
    logic signed [127:0] rad [3];
    logic signed [127:0] dot, t_ax, e_unit, prod, lim_hi, lim_lo;
    logic [63:0] mag [3];
    logic [63:0] peak, ssq, root;
    int len;
    force_result_t res;
    ofs[0] = px; ofs[1] = py; ofs[2] = pz;
    dot = '0;
    for (int i = 0; i < 3; i++) begin
      ofs[i] = ofs[i] - axis_pt[i];
      dir[i] = axis_dir[i];
      dot    = dot + ofs[i] * dir[i];
    end
    t_ax = (dot + 128'sd8192) >>> DIR_FRAC;
    peak = '0;
    for (int i = 0; i < 3; i++) begin
      rad[i] = ofs[i] - ((t_ax * dir[i] + 128'sd8192) >>> DIR_FRAC);
      mag[i] = (rad[i] < 0) ? 64'(-rad[i]) : 64'(rad[i]);
      if (mag[i] > peak) peak = mag[i];
    end
    res.body_id = id;
    res.fx = '0; res.fy = '0; res.fz = '0;
    res.on_axis = (peak == 0);
    if (peak == 0) return res;
    // Common shift so the largest component lands in [2^29, 2^30)
    len = 0;
    for (int b = 0; b < 64; b++) if (peak[b]) len = b + 1;
    ssq = '0;
    for (int i = 0; i < 3; i++) begin
      if (len > NORM_W) mag[i] = mag[i] >> (len - NORM_W);
      else mag[i] = mag[i] << (NORM_W - len);
      ssq = ssq + mag[i] * mag[i];
    end
    root   = int_sqrt(ssq);
    lim_hi = 128'sd2147483647;
    lim_lo = -128'sd2147483648;
    for (int i = 0; i < 3; i++) begin
      e_unit = {64'b0, ((mag[i] << UNIT_FRAC) + (root >> 1)) / root};
      if (rad[i] < 0) e_unit = -e_unit;
      prod = (force_mag * e_unit + (128'sd1 <<< (UNIT_FRAC - 1))) >>> UNIT_FRAC;
      if (prod > lim_hi) prod = lim_hi;
      if (prod < lim_lo) prod = lim_lo;
      case (i)
        0: res.fx = prod[31:0];
        1: res.fy = prod[31:0];
        default: res.fz = prod[31:0];
      endcase
    end
    return res;
  endfunction

  assign pending_forces = expected_forces.size();

  always @(posedge clk) begin
    force_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        axis_pt[i]  = '0;
        axis_dir[i] = '0;
      end
      axis_dir[2] = DIR_Z_RESET;
      force_mag   = '0;
      expected_forces.delete();
    end else begin
      // Register writes land at the access cycle
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_PT_X:  axis_pt[0]  = pwdata;
          REG_PT_Y:  axis_pt[1]  = pwdata;
          REG_PT_Z:  axis_pt[2]  = pwdata;
          REG_DIR_X: axis_dir[0] = pwdata[15:0];
          REG_DIR_Y: axis_dir[1] = pwdata[15:0];
          REG_DIR_Z: axis_dir[2] = pwdata[15:0];
          REG_FMAG:  force_mag   = pwdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_forces.push_back(radial_force(in_body_id, in_pos_x, in_pos_y, in_pos_z));
      // Compare each accepted result against the oldest prediction
      if (out_valid && !out_stall) begin
        forces_checked++;
        if (expected_forces.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result id %h", $realtime, out_body_id);
        end else begin
          want = expected_forces.pop_front();
          if (out_body_id !== want.body_id) begin
            fail_count++;
            $display("%0t: body_id exp %h got %h", $realtime, want.body_id, out_body_id);
          end
          if (out_force_x !== want.fx) begin
            fail_count++;
            $display("%0t: force_x exp %h got %h", $realtime, want.fx, out_force_x);
          end
          if (out_force_y !== want.fy) begin
            fail_count++;
            $display("%0t: force_y exp %h got %h", $realtime, want.fy, out_force_y);
          end
          if (out_force_z !== want.fz) begin
            fail_count++;
            $display("%0t: force_z exp %h got %h", $realtime, want.fz, out_force_z);
          end
          if (out_on_axis !== want.on_axis) begin
            fail_count++;
            $display("%0t: on_axis exp %b got %b", $realtime, want.on_axis, out_on_axis);
          end
        end
      end
    end
  end

  initial begin
    fail_count     = 0;
    forces_checked = 0;
  end
endmodule

// File: tb/radial_axis_force_unit_tb.sv
// Top of the radial axis force testbench: clock, reset, config phases, body stimulus, verdict.
module radial_axis_force_unit_tb
  import raf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [REG_IDX_W-1:0] REG_IDX_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_body_id = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_body_id;
  logic signed [31:0] out_force_x, out_force_y, out_force_z;
  logic out_on_axis;

  int fail_count, pending_forces, forces_checked;
  int bodies_sent = 0;
  int burst_left = 0;
  bit hold_go = 1'b0;

  // Stimulus-side copy of the axis, used only to aim bodies at it
  logic signed [31:0] cur_pt [3];
  logic signed [15:0] cur_dir [3];

  always #6 clk = ~clk;

  radial_axis_force_unit uut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_body_id(in_body_id),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .out_valid(out_valid), .out_stall(out_stall), .out_body_id(out_body_id),
    .out_force_x(out_force_x), .out_force_y(out_force_y), .out_force_z(out_force_z),
    .out_on_axis(out_on_axis)
  );

  radial_axis_force_checker chk (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_body_id(in_body_id),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .out_valid(out_valid), .out_stall(out_stall), .out_body_id(out_body_id),
    .out_force_x(out_force_x), .out_force_y(out_force_y), .out_force_z(out_force_z),
    .out_on_axis(out_on_axis),
    .fail_count(fail_count), .pending_forces(pending_forces),
    .forces_checked(forces_checked)
  );

  // Result side stall: changing patterns plus one long hold-off
  initial begin
    int mode, mode_left, hold_left;
    bit hold_done;
    mode = 0; mode_left = 0; hold_left = 0; hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= mode_left[0];
        endcase
      end
    end
  end

  task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Drain the pipe, then load a whole axis setup
  task automatic load_axis(logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [31:0] pz, logic signed [15:0] dx,
                           logic signed [15:0] dy, logic signed [15:0] dz,
                           logic signed [31:0] fmag);
    in_valid <= 1'b0;
    while (pending_forces != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    reg_write(REG_PT_X, px);
    reg_write(REG_PT_Y, py);
    reg_write(REG_PT_Z, pz);
    reg_write(REG_DIR_X, {{16{dx[15]}}, dx});
    reg_write(REG_DIR_Y, {{16{dy[15]}}, dy});
    reg_write(REG_DIR_Z, {{16{dz[15]}}, dz});
    reg_write(REG_FMAG, fmag);
    cur_pt[0] = px; cur_pt[1] = py; cur_pt[2] = pz;
    cur_dir[0] = dx; cur_dir[1] = dy; cur_dir[2] = dz;
  endtask

  // Offer one body request and hold it until taken; bursts with gaps between
  task automatic send_body(logic [15:0] id, logic signed [31:0] px,
                           logic signed [31:0] py, logic signed [31:0] pz);
    int gap;
    in_valid <= 1'b1;
    in_body_id <= id; in_pos_x <= px; in_pos_y <= py; in_pos_z <= pz;
    do @(posedge clk); while (in_stall);
    bodies_sent++;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic signed [31:0] pick_coord(int axis);
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2:    return cur_pt[axis] + $signed(32'($urandom_range(0, 2000)) - 32'sd1000);
      3:    return cur_pt[axis];
      4:    return 32'sh7fffffff;
      5:    return 32'sh80000000;
      default: return cur_pt[axis] + $signed({{12{1'b0}}, 20'($urandom)}) - 32'sd524288;
    endcase
  endfunction

  // Random bodies: mostly spread, some right on or near the axis line
  task automatic random_bodies(int count);
    logic signed [31:0] p [3];
    int along;
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < 3; k++) p[k] = pick_coord(k);
      if ($urandom_range(0, 5) == 0) begin
        along = $signed(32'($urandom_range(0, 2000))) - 1000;
        for (int k = 0; k < 3; k++) p[k] = cur_pt[k] + along * cur_dir[k];
      end
      send_body(16'($urandom), p[0], p[1], p[2]);
    end
  endtask

  initial begin
    cur_pt[0] = '0; cur_pt[1] = '0; cur_pt[2] = '0;
    cur_dir[0] = '0; cur_dir[1] = '0; cur_dir[2] = DIR_Z_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setup: axis along z, zero magnitude
    send_body(16'h0000, 32'sd0, 32'sd0, 32'sd12345);
    send_body(16'hffff, 32'sh7fffffff, 32'sh80000000, 32'sd0);
    random_bodies(150);

    // Unit magnitude along x, directed extremes
    load_axis(32'sd0, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 32'sd65536);
    send_body(16'h0001, 32'sh7fffffff, 32'sd0, 32'sd0);
    send_body(16'h0002, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_body(16'h0003, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_body(16'h0004, 32'sh80000000, 32'sh7fffffff, 32'sd0);
    send_body(16'h0005, 32'sd7, 32'sd1, 32'sd0);
    send_body(16'h0006, 32'sd0, 32'sd0, -32'sd1);
    send_body(16'haaaa, 32'sd0, 32'sd3, 32'sd4);
    send_body(16'h5555, 32'sd100, 32'sh40000000, -32'sh40000000);
    random_bodies(250);

    // Largest magnitude, lowest point, axis along z: saturation
    load_axis(32'sh80000000, 32'sh80000000, 32'sh80000000,
              16'sd0, 16'sd0, 16'sd16384, 32'sh7fffffff);
    send_body(16'h0010, 32'sh80000000, 32'sh80000000, 32'sd0);
    send_body(16'h0011, 32'sh7fffffff, 32'sh80000000, 32'sd0);
    send_body(16'h0012, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    random_bodies(80);
    hold_go = 1'b1;
    random_bodies(220);

    // Diagonal axis, most negative magnitude, highest point
    load_axis(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
              16'sd9459, 16'sd9459, 16'sd9459, 32'sh80000000);
    send_body(16'h0020, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_body(16'h0021, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    random_bodies(250);

    // Unnormalized direction; the unmapped register must be ignored
    load_axis($urandom, $urandom, $urandom, 16'sh8000, 16'sh7fff, -16'sd16384, $urandom);
    reg_write(REG_IDX_UNUSED, 32'hffffffff);
    send_body(16'h0030, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    random_bodies(100);
    for (int s = 0; s < 4; s++) begin
      load_axis($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                16'($urandom), $urandom);
      random_bodies(80);
    end

    in_valid <= 1'b0;
    while (pending_forces != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d bodies over nine axis setups, checked %0d force results,",
             bodies_sent, forces_checked);
    $display("including saturation, on-axis, unnormalized axis and a long output hold.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
